FILE: rtl/core/hlc_pkg.sv
// ============================================================================
// hlc_pkg: shared constants for the hex lattice competition update
// Kind codes, command codes, register indexes and default lattice size.
// ============================================================================
package hlc_pkg;

   // default lattice size
   localparam int ROWS_DEFAULT    = 64;
   localparam int COLUMNS_DEFAULT = 256;

   // field widths
   localparam int RAND_W = 16;
   localparam int WGT_W  = 16;

   // kind 2 has a fixed weight of 1.0 in Q1.15
   localparam logic [WGT_W-1:0] UNIT_WEIGHT = 16'h8000;

   // cell kinds
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_RESIDENT = 2'd1;
   localparam logic [1:0] KIND_INVADER  = 2'd2;
   localparam logic [1:0] KIND_MUTANT   = 2'd3;

   // request commands
   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_WEIGHT_RESIDENT    = 2'd0;
   localparam logic [1:0] CSR_WEIGHT_MUTANT      = 2'd1;
   localparam logic [1:0] CSR_MUTATION_THRESHOLD = 2'd2;

endpackage

FILE: rtl/core/hlc_serial_mul.sv
// ============================================================================
// hlc_serial_mul: shift-add multiplier
// Multiplies an A_W-bit value by a 16-bit fraction, one multiplier bit a cycle.
// ============================================================================
module hlc_serial_mul #(
   parameter int A_W = 34
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [A_W-1:0]                a,
   input  logic [hlc_pkg::RAND_W-1:0]    b,
   output logic                          done,
   output logic [A_W+hlc_pkg::RAND_W-1:0] product
);

   localparam int P_W = A_W + hlc_pkg::RAND_W;
   localparam int B_CNT_W = $clog2(hlc_pkg::RAND_W + 1);

   logic [P_W-1:0]             acc_ff;
   logic [P_W-1:0]             a_ff;
   logic [hlc_pkg::RAND_W-1:0] b_ff;
   logic [B_CNT_W-1:0]         bits_ff;
   logic                       busy_ff;
   logic                       done_ff;

   // one partial product per cycle, LSB of b first
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff  <= '0;
            a_ff    <= P_W'(a);
            b_ff    <= b;
            bits_ff <= B_CNT_W'(hlc_pkg::RAND_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + a_ff;
            end
            a_ff    <= a_ff << 1;
            b_ff    <= b_ff >> 1;
            bits_ff <= bits_ff - B_CNT_W'(1);
            if (bits_ff == B_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

FILE: rtl/core/hex_lattice_competition_update.sv
// ============================================================================
// hex_lattice_competition_update: kinetic Monte Carlo step on a hex lattice
// Keeps the lattice kinds and the active-cell list in on-chip memories and
// runs one start or one update event per request word.
// ============================================================================
//
//   channel  direction  handshake             contents
//   req_*    in         req_valid/req_ready   func, rand_site/compete/mutate
//   rsp_*    out        rsp_valid/rsp_ready   site, old/new type, flags, total
//   csr_*    in         csr_write_enable      index, write data (no read-back)
//
// Start word: every cell of the lattice is written, one cell written per cycle.
// Update word on an empty list: no walk, only an empty-list result.
// Update word: the roulette walk reads one list entry a cycle; when the
// kind changes, each of the seven touched cells is refreshed, with extra
// steps for a cell that leaves the list.
// One word is worked at a time; a finished result waits in the output
// register while the next word is taken. Lattice memories need no clearing
// after reset: the list is empty until the first start word.
module hex_lattice_competition_update #(
   parameter int ROWS    = hlc_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = hlc_pkg::COLUMNS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [15:0] req_rand_site,
   input  logic [15:0] req_rand_compete,
   input  logic [15:0] req_rand_mutate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_site_row,
   output logic [7:0]  rsp_site_col,
   output logic [1:0]  rsp_old_type,
   output logic [1:0]  rsp_new_type,
   output logic        rsp_changed,
   output logic [14:0] rsp_active_total,
   output logic        rsp_no_active,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int AW    = RW + CW;
   localparam int CELLS = ROWS * COLUMNS;
   localparam int SW    = $clog2(CELLS);
   localparam int NW    = $clog2(CELLS + 1);
   localparam int EW    = AW + 2;
   localparam int DW    = hlc_pkg::WGT_W + NW + 2;
   localparam int TW    = DW + hlc_pkg::RAND_W;
   localparam int LEFT  = COLUMNS / 2 - ROWS / 4;
   localparam int RIGHT = COLUMNS / 2 + ROWS / 4;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_DEN, S_MULGO, S_MUL, S_WALK, S_PICK0, S_PICK0W,
      S_NBR, S_COMP1, S_COMP2, S_COMP3, S_WRITE, S_RF_RD, S_RF_EVAL,
      S_RM_RD, S_RM_WR, S_DONE
   } state_type;

   // neighbor n of a cell; n = 6 (and above) is the cell itself
   function automatic logic [AW-1:0] nbr_addr(input logic [AW-1:0] a,
                                               input logic [2:0] n);
      logic [RW-1:0] r, rl, rr, sd;
      logic [CW-1:0] c, cu, cd;
      logic [AW-1:0] o;
      r  = a[AW-1:CW];
      c  = a[CW-1:0];
      rl = (r == '0) ? RW'(ROWS - 1) : r - RW'(1);
      rr = (r == RW'(ROWS - 1)) ? '0 : r + RW'(1);
      cu = (c == '0) ? CW'(COLUMNS - 1) : c - CW'(1);
      cd = (c == CW'(COLUMNS - 1)) ? '0 : c + CW'(1);
      sd = c[0] ? rl : rr;
      case (n)
         3'd0: o = {rl, c};
         3'd1: o = {rr, c};
         3'd2: o = {r, cu};
         3'd3: o = {sd, cu};
         3'd4: o = {r, cd};
         3'd5: o = {sd, cd};
         default: o = a;
      endcase
      return o;
   endfunction

   function automatic logic [hlc_pkg::WGT_W-1:0] kind_wgt(
      input logic [1:0] k, input logic [hlc_pkg::WGT_W-1:0] wr,
      input logic [hlc_pkg::WGT_W-1:0] wm);
      logic [hlc_pkg::WGT_W-1:0] w;
      case (k)
         hlc_pkg::KIND_RESIDENT: w = wr;
         hlc_pkg::KIND_INVADER:  w = hlc_pkg::UNIT_WEIGHT;
         hlc_pkg::KIND_MUTANT:   w = wm;
         default:                w = '0;
      endcase
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // configuration registers
   logic [15:0] wr_ff, wm_ff, thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 16'h8000;
         wm_ff  <= 16'h8000;
         thr_ff <= 16'h0000;
      end else if (csr_write_enable) begin
         case (csr_index)
            hlc_pkg::CSR_WEIGHT_RESIDENT:    wr_ff  <= csr_write_data;
            hlc_pkg::CSR_WEIGHT_MUTANT:      wm_ff  <= csr_write_data;
            hlc_pkg::CSR_MUTATION_THRESHOLD: thr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // memories: lattice kinds, listed flags, list slots, list entries
   logic [1:0]    kind_mem   [2**AW];
   logic          listed_mem [2**AW];
   logic [SW-1:0] slot_mem   [2**AW];
   logic [EW-1:0] ent_mem    [CELLS];

   logic          kind_we, listed_we, slot_we, ent_we, listed_wdata;
   logic [AW-1:0] kind_waddr, listed_waddr, slot_waddr;
   logic [AW-1:0] kind_raddr, listed_raddr, slot_raddr;
   logic [1:0]    kind_wdata;
   logic [SW-1:0] slot_wdata, ent_waddr, ent_raddr;
   logic [EW-1:0] ent_wdata;
   logic [1:0]    kind_q;
   logic          listed_q;
   logic [SW-1:0] slot_q;
   logic [EW-1:0] ent_q;

   always_ff @(posedge clock) begin
      if (kind_we) kind_mem[kind_waddr] <= kind_wdata;
      kind_q <= kind_mem[kind_raddr];
   end

   always_ff @(posedge clock) begin
      if (listed_we) listed_mem[listed_waddr] <= listed_wdata;
      listed_q <= listed_mem[listed_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_q <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      ent_q <= ent_mem[ent_raddr];
   end

   // ---------------------------------------------------------------------
   // work registers
   state_type     state_ff;
   logic          func_ff, empty_ff;
   logic [15:0]   rsite_ff, rcomp_ff, rmut_ff;
   logic [NW-1:0] count_ff;
   logic [NW-1:0] kcnt_ff [3];
   logic [RW-1:0] init_r_ff;
   logic [CW-1:0] init_c_ff;
   logic [1:0]    k_ff;
   logic [DW-1:0] den_ff, cum_ff;
   logic [NW-1:0] walk_ff, widx_ff;
   logic          wv_ff;
   logic [SW-1:0] pick_ff;
   logic [AW-1:0] center_ff;
   logic [2:0]    st_ff, rj_ff;
   logic [1:0]    nk_ff [7];
   logic [1:0]    rk_ff [7];
   logic          same_ff;
   logic [18:0]   a1_ff, a2_ff, d_ff;
   logic [34:0]   rd_ff;
   logic [1:0]    win_ff;
   logic          rf_listed_ff;
   logic [SW-1:0] rf_slot_ff;

   logic          rsp_valid_ff, rsp_changed_ff, rsp_no_active_ff;
   logic [5:0]    rsp_row_ff;
   logic [7:0]    rsp_col_ff;
   logic [1:0]    rsp_old_ff, rsp_new_ff;
   logic [14:0]   rsp_total_ff;

   // target = rand_site * total weight, from the serial multiplier
   logic          mul_start, mul_done;
   logic [TW-1:0] target;

   hlc_serial_mul #(.A_W(DW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (den_ff),
      .b       (rsite_ff),
      .done    (mul_done),
      .product (target)
   );

   assign mul_start = (state_ff == S_MULGO);

   // ---------------------------------------------------------------------
   // decode of the current step
   logic [1:0]    init_kind;
   logic          init_edge;
   logic [AW-1:0] ent_addr, rf_x;
   logic [1:0]    ent_kind;
   logic [DW-1:0] cum_nx;
   logic          walk_hit;
   logic          rf_uni, add_ok, rm_ok;
   logic [2:0]    t1, t2, t3;
   logic          same_c;
   logic [18:0]   p1, p2, p3;
   logic [1:0]    win_c;
   logic [NW-1:0] den_cnt;
   logic [hlc_pkg::WGT_W-1:0] den_w;

   always_comb begin
      init_kind = (int'(init_c_ff) > LEFT && int'(init_c_ff) <= RIGHT)
                  ? hlc_pkg::KIND_INVADER : hlc_pkg::KIND_RESIDENT;
      init_edge = (int'(init_c_ff) == LEFT) || (int'(init_c_ff) == LEFT + 1) ||
                  (int'(init_c_ff) == RIGHT) || (int'(init_c_ff) == RIGHT + 1);
      ent_addr  = ent_q[EW-1:2];
      ent_kind  = ent_q[1:0];
      cum_nx    = cum_ff + DW'(kind_wgt(ent_kind, wr_ff, wm_ff));
      walk_hit  = {cum_nx, 16'h0000} > target;
      rf_x      = nbr_addr(center_ff, rj_ff);
      rf_uni    = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (rk_ff[i] != rk_ff[6]) rf_uni = 1'b0;
      end
      add_ok = !rf_listed_ff && !rf_uni && (count_ff < NW'(CELLS));
      rm_ok  = (count_ff != '0) && (NW'(rf_slot_ff) < count_ff);
   end

   // neighbor kind tally and weights
   always_comb begin
      t1 = '0;
      t2 = '0;
      t3 = '0;
      same_c = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (nk_ff[i] == hlc_pkg::KIND_RESIDENT) t1 = t1 + 3'd1;
         if (nk_ff[i] == hlc_pkg::KIND_INVADER)  t2 = t2 + 3'd1;
         if (nk_ff[i] == hlc_pkg::KIND_MUTANT)   t3 = t3 + 3'd1;
         if (nk_ff[i] != nk_ff[0]) same_c = 1'b0;
      end
      p1 = 19'(wr_ff * t1);
      p2 = 19'(hlc_pkg::UNIT_WEIGHT * t2);
      p3 = 19'(wm_ff * t3);
   end

   // competition winner plus mutation
   always_comb begin
      if (same_ff) begin
         win_c = nk_ff[0];
      end else if (d_ff == '0) begin
         win_c = nk_ff[6];
      end else if ({a1_ff, 16'h0000} > rd_ff) begin
         win_c = hlc_pkg::KIND_RESIDENT;
      end else if ({a2_ff, 16'h0000} > rd_ff) begin
         win_c = hlc_pkg::KIND_INVADER;
      end else begin
         win_c = hlc_pkg::KIND_MUTANT;
      end
      if (win_c == hlc_pkg::KIND_INVADER && thr_ff != '0 && rmut_ff < thr_ff) begin
         win_c = hlc_pkg::KIND_MUTANT;
      end
   end

   // one kind count and weight per cycle for the total weight
   always_comb begin
      case (k_ff)
         2'd0: begin
            den_cnt = kcnt_ff[0];
            den_w   = wr_ff;
         end
         2'd1: begin
            den_cnt = kcnt_ff[1];
            den_w   = hlc_pkg::UNIT_WEIGHT;
         end
         default: begin
            den_cnt = kcnt_ff[2];
            den_w   = wm_ff;
         end
      endcase
   end

   // memory port steering
   always_comb begin
      kind_we      = 1'b0;
      kind_waddr   = center_ff;
      kind_wdata   = win_ff;
      kind_raddr   = center_ff;
      listed_we    = 1'b0;
      listed_waddr = rf_x;
      listed_wdata = 1'b0;
      listed_raddr = rf_x;
      slot_we      = 1'b0;
      slot_waddr   = rf_x;
      slot_wdata   = count_ff[SW-1:0];
      slot_raddr   = rf_x;
      ent_we       = 1'b0;
      ent_waddr    = count_ff[SW-1:0];
      ent_wdata    = {rf_x, rk_ff[6]};
      ent_raddr    = '0;
      case (state_ff)
         S_INIT: begin
            kind_we      = 1'b1;
            kind_waddr   = {init_r_ff, init_c_ff};
            kind_wdata   = init_kind;
            listed_we    = 1'b1;
            listed_waddr = {init_r_ff, init_c_ff};
            listed_wdata = init_edge;
            if (init_edge) begin
               slot_we    = 1'b1;
               slot_waddr = {init_r_ff, init_c_ff};
               ent_we     = 1'b1;
               ent_wdata  = {init_r_ff, init_c_ff, init_kind};
            end
         end
         S_WALK: ent_raddr = walk_ff[SW-1:0];
         S_NBR:  kind_raddr = nbr_addr(center_ff, st_ff);
         S_WRITE: begin
            kind_we   = 1'b1;
            ent_we    = 1'b1;
            ent_waddr = pick_ff;
            ent_wdata = {center_ff, win_ff};
         end
         S_RF_RD: kind_raddr = nbr_addr(rf_x, st_ff);
         S_RF_EVAL: begin
            if (add_ok) begin
               ent_we       = 1'b1;
               listed_we    = 1'b1;
               listed_wdata = 1'b1;
               slot_we      = 1'b1;
            end
         end
         S_RM_RD: ent_raddr = SW'(count_ff - NW'(1));
         S_RM_WR: begin
            if (rm_ok) begin
               ent_we     = 1'b1;
               ent_waddr  = rf_slot_ff;
               ent_wdata  = ent_q;
               slot_we    = 1'b1;
               slot_waddr = ent_addr;
               slot_wdata = rf_slot_ff;
               listed_we  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) kcnt_ff[k] <= '0;
      end else begin
         // S_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff  <= req_func;
                  rsite_ff <= req_rand_site;
                  rcomp_ff <= req_rand_compete;
                  rmut_ff  <= req_rand_mutate;
                  empty_ff <= 1'b0;
                  if (req_func == hlc_pkg::FUNC_START) begin
                     count_ff  <= '0;
                     for (int k = 0; k < 3; k++) kcnt_ff[k] <= '0;
                     init_r_ff <= '0;
                     init_c_ff <= '0;
                     state_ff  <= S_INIT;
                  end else if (count_ff == '0) begin
                     empty_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     k_ff     <= '0;
                     den_ff   <= '0;
                     state_ff <= S_DEN;
                  end
               end
            end
            // paint the lattice, list the stripe borders
            S_INIT: begin
               if (init_edge) begin
                  count_ff <= count_ff + NW'(1);
                  for (int k = 0; k < 3; k++) begin
                     if (init_kind == 2'(k + 1)) kcnt_ff[k] <= kcnt_ff[k] + NW'(1);
                  end
               end
               if (init_c_ff == CW'(COLUMNS - 1)) begin
                  init_c_ff <= '0;
                  init_r_ff <= init_r_ff + RW'(1);
                  if (init_r_ff == RW'(ROWS - 1)) state_ff <= S_DONE;
               end else begin
                  init_c_ff <= init_c_ff + CW'(1);
               end
            end
            S_DEN: begin
               den_ff <= den_ff + DW'(den_w * den_cnt);
               k_ff   <= k_ff + 2'd1;
               if (k_ff == 2'd2) state_ff <= S_MULGO;
            end
            S_MULGO: state_ff <= S_MUL;
            S_MUL: begin
               if (mul_done) begin
                  walk_ff  <= '0;
                  wv_ff    <= 1'b0;
                  cum_ff   <= '0;
                  state_ff <= S_WALK;
               end
            end
            // roulette walk, one entry a cycle
            S_WALK: begin
               walk_ff <= walk_ff + NW'(1);
               wv_ff   <= walk_ff < count_ff;
               widx_ff <= walk_ff;
               if (wv_ff) begin
                  cum_ff <= cum_nx;
                  if (walk_hit) begin
                     pick_ff   <= widx_ff[SW-1:0];
                     center_ff <= ent_addr;
                     st_ff     <= '0;
                     state_ff  <= S_NBR;
                  end else if (widx_ff == count_ff - NW'(1)) begin
                     state_ff <= S_PICK0;
                  end
               end
            end
            S_PICK0: state_ff <= S_PICK0W;
            S_PICK0W: begin
               pick_ff   <= '0;
               center_ff <= ent_addr;
               st_ff     <= '0;
               state_ff  <= S_NBR;
            end
            // six neighbor kinds, then the cell's own
            S_NBR: begin
               st_ff <= st_ff + 3'd1;
               if (st_ff != 3'd0) nk_ff[st_ff - 3'd1] <= kind_q;
               if (st_ff == 3'd7) state_ff <= S_COMP1;
            end
            S_COMP1: begin
               same_ff  <= same_c;
               a1_ff    <= p1;
               a2_ff    <= p1 + p2;
               d_ff     <= p1 + p2 + p3;
               state_ff <= S_COMP2;
            end
            S_COMP2: begin
               rd_ff    <= rcomp_ff * d_ff;
               state_ff <= S_COMP3;
            end
            S_COMP3: begin
               win_ff   <= win_c;
               state_ff <= (win_c != nk_ff[6]) ? S_WRITE : S_DONE;
            end
            S_WRITE: begin
               for (int k = 0; k < 3; k++) begin
                  kcnt_ff[k] <= kcnt_ff[k] - NW'(nk_ff[6] == 2'(k + 1))
                                           + NW'(win_ff == 2'(k + 1));
               end
               rj_ff    <= '0;
               st_ff    <= '0;
               state_ff <= S_RF_RD;
            end
            // list refresh for the touched cells
            S_RF_RD: begin
               st_ff <= st_ff + 3'd1;
               if (st_ff != 3'd0) rk_ff[st_ff - 3'd1] <= kind_q;
               if (st_ff == 3'd1) begin
                  rf_listed_ff <= listed_q;
                  rf_slot_ff   <= slot_q;
               end
               if (st_ff == 3'd7) state_ff <= S_RF_EVAL;
            end
            S_RF_EVAL: begin
               if (rf_listed_ff && rf_uni) begin
                  state_ff <= S_RM_RD;
               end else begin
                  if (add_ok) begin
                     count_ff <= count_ff + NW'(1);
                     for (int k = 0; k < 3; k++) begin
                        if (rk_ff[6] == 2'(k + 1)) kcnt_ff[k] <= kcnt_ff[k] + NW'(1);
                     end
                  end
                  st_ff <= '0;
                  rj_ff <= rj_ff + 3'd1;
                  state_ff <= (rj_ff == 3'd6) ? S_DONE : S_RF_RD;
               end
            end
            S_RM_RD: state_ff <= S_RM_WR;
            // move the last entry into the freed slot
            S_RM_WR: begin
               if (rm_ok) begin
                  count_ff <= count_ff - NW'(1);
                  for (int k = 0; k < 3; k++) begin
                     if (rk_ff[6] == 2'(k + 1)) kcnt_ff[k] <= kcnt_ff[k] - NW'(1);
                  end
               end
               st_ff <= '0;
               rj_ff <= rj_ff + 3'd1;
               state_ff <= (rj_ff == 3'd6) ? S_DONE : S_RF_RD;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_total_ff <= 15'(count_ff);
                  if (func_ff == hlc_pkg::FUNC_START || empty_ff) begin
                     rsp_row_ff       <= '0;
                     rsp_col_ff       <= '0;
                     rsp_old_ff       <= hlc_pkg::KIND_NONE;
                     rsp_new_ff       <= hlc_pkg::KIND_NONE;
                     rsp_changed_ff   <= 1'b0;
                     rsp_no_active_ff <= empty_ff;
                  end else begin
                     rsp_row_ff       <= 6'(center_ff[AW-1:CW]);
                     rsp_col_ff       <= 8'(center_ff[CW-1:0]);
                     rsp_old_ff       <= nk_ff[6];
                     rsp_new_ff       <= win_ff;
                     rsp_changed_ff   <= win_ff != nk_ff[6];
                     rsp_no_active_ff <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_site_row     = rsp_row_ff;
   assign rsp_site_col     = rsp_col_ff;
   assign rsp_old_type     = rsp_old_ff;
   assign rsp_new_type     = rsp_new_ff;
   assign rsp_changed      = rsp_changed_ff;
   assign rsp_active_total = rsp_total_ff;
   assign rsp_no_active    = rsp_no_active_ff;

endmodule

FILE: rtl/core/hlc_checker.sv
// ============================================================================
// hlc_checker: port-level checks for the hex lattice competition update
// Watches the result channel for consistency of its flags over time.
// ============================================================================
module hlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_site_row,
   input logic [7:0]  rsp_site_col,
   input logic [1:0]  rsp_old_type,
   input logic [1:0]  rsp_new_type,
   input logic        rsp_changed,
   input logic [14:0] rsp_active_total,
   input logic        rsp_no_active
);

   // a stalled result word holds its new kind, site and total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_type) &&
      $stable(rsp_site_row) && $stable(rsp_site_col) && $stable(rsp_active_total))
      else $error("result word changed while stalled");

   // changed flag agrees with the kinds
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_old_type != rsp_new_type)
      else $error("changed set with equal kinds");

   a_unchanged: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_changed |-> rsp_old_type == rsp_new_type)
      else $error("kinds differ without change");

   // empty list: nothing updated, nothing listed
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_active |-> !rsp_changed && rsp_active_total == 15'd0 &&
      rsp_new_type == hlc_pkg::KIND_NONE)
      else $error("empty-list result carries an update");

endmodule

bind hex_lattice_competition_update hlc_checker u_hlc_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for hex_lattice_competition_update
// A driver sends start and update words from a queue, with bursts and gaps. A
// monitor checks each result word against a lattice model that the bench keeps
// itself, under changing stall patterns and one long output hold-off. Register
// settings change between phases, with the extremes among them.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS      = hlc_pkg::ROWS_DEFAULT;
   localparam int COLS      = hlc_pkg::COLUMNS_DEFAULT;
   localparam int CELLS     = ROWS * COLS;
   localparam int CYCLE_CAP = 8000000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;  // no register behind this index

   typedef struct {
      logic        func;
      logic [15:0] site_draw;
      logic [15:0] compete_draw;
      logic [15:0] mutate_draw;
   } event_word_type;

   typedef struct {
      logic [5:0]  row;
      logic [7:0]  col;
      logic [1:0]  old_kind;
      logic [1:0]  new_kind;
      logic        changed;
      logic [14:0] total;
      logic        empty;
   } site_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_func = 0;
   logic [15:0] req_rand_site = 0;
   logic [15:0] req_rand_compete = 0;
   logic [15:0] req_rand_mutate = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [5:0]  rsp_site_row;
   logic [7:0]  rsp_site_col;
   logic [1:0]  rsp_old_type;
   logic [1:0]  rsp_new_type;
   logic        rsp_changed;
   logic [14:0] rsp_active_total;
   logic        rsp_no_active;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_write_data = 0;

   hex_lattice_competition_update dut (.*);

   always #2 clock = ~clock;

   // ---------------- lattice model ----------------
   logic [15:0] wgt_resident = 16'd32768;
   logic [15:0] wgt_mutant   = 16'd32768;
   logic [15:0] mut_thresh   = 16'd0;

   logic [1:0]  kind_map   [CELLS];
   bit          on_list    [CELLS];
   int unsigned list_slot  [CELLS];
   int unsigned entry_cell [CELLS];
   logic [1:0]  entry_kind [CELLS];
   int unsigned kind_tally [4];
   int unsigned list_len = 0;

   function automatic longint unsigned kind_weight(logic [1:0] k);
      case (k)
         hlc_pkg::KIND_RESIDENT: return 64'(wgt_resident);
         hlc_pkg::KIND_INVADER:  return 64'(hlc_pkg::UNIT_WEIGHT);
         hlc_pkg::KIND_MUTANT:   return 64'(wgt_mutant);
         default:                return 0;
      endcase
   endfunction

   function automatic void hex_neighbours(input int unsigned site,
                                          output int unsigned nb[6]);
      int unsigned r, c, rl, rr, cu, cd, side;
      r = site / COLS;
      c = site % COLS;
      rl = (r + ROWS - 1) % ROWS;
      rr = (r + 1) % ROWS;
      cu = (c + COLS - 1) % COLS;
      cd = (c + 1) % COLS;
      side = c[0] ? rl : rr;   // odd columns lean up, even ones down
      nb[0] = rl * COLS + c;
      nb[1] = rr * COLS + c;
      nb[2] = r * COLS + cu;
      nb[3] = side * COLS + cu;
      nb[4] = r * COLS + cd;
      nb[5] = side * COLS + cd;
   endfunction

   function automatic bit all_alike(int unsigned site);
      int unsigned nb[6];
      hex_neighbours(site, nb);
      foreach (nb[i]) if (kind_map[nb[i]] != kind_map[site]) return 0;
      return 1;
   endfunction

   function automatic void list_push(int unsigned site);
      if (list_len >= CELLS) return;
      entry_cell[list_len] = site;
      entry_kind[list_len] = kind_map[site];
      on_list[site] = 1;
      list_slot[site] = list_len;
      list_len++;
      kind_tally[kind_map[site]]++;
   endfunction

   // swap-removal: last entry moves into the freed slot
   function automatic void list_drop(int unsigned site);
      int unsigned idx;
      idx = list_slot[site];
      if (list_len == 0 || idx >= list_len) return;
      entry_cell[idx] = entry_cell[list_len-1];
      entry_kind[idx] = entry_kind[list_len-1];
      list_slot[entry_cell[idx]] = idx;
      on_list[site] = 0;
      list_slot[site] = 0;
      list_len--;
      kind_tally[kind_map[site]]--;
   endfunction

   function automatic site_result_type lattice_event(event_word_type w);
      site_result_type res;
      longint unsigned denom, cum, target, d, acc;
      int unsigned pick, site, x, left, right;
      int unsigned nb[6];
      int unsigned t[4];
      logic [1:0] nk[6];
      logic [1:0] old_k, winner;
      bit same;
      res = '{default: '0};
      if (w.func == hlc_pkg::FUNC_START) begin
         // invader stripe between left and right, both stripe edges listed
         left = COLS/2 - ROWS/4;
         right = COLS/2 + ROWS/4;
         kind_tally = '{default: 0};
         list_len = 0;
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               site = r * COLS + c;
               kind_map[site] = (c > left && c <= right) ? hlc_pkg::KIND_INVADER
                                                         : hlc_pkg::KIND_RESIDENT;
               on_list[site] = 0;
               list_slot[site] = 0;
               if (c == left || c == left+1 || c == right || c == right+1)
                  list_push(site);
            end
         end
      end else if (list_len == 0) begin
         res.empty = 1;
      end else begin
         // weighted roulette over the active list
         denom = 0;
         cum = 0;
         pick = 0;
         for (int k = 1; k <= 3; k++) denom += kind_weight(2'(k)) * kind_tally[k];
         target = longint'(w.site_draw) * denom;
         for (int i = 0; i < list_len; i++) begin
            cum += kind_weight(entry_kind[i]);
            if (cum * 65536 > target) begin
               pick = i;
               break;
            end
         end
         site = entry_cell[pick] % CELLS;
         res.row = 6'(site / COLS);
         res.col = 8'(site % COLS);
         old_k = kind_map[site];
         res.old_kind = old_k;
         // competition among the six neighbours
         hex_neighbours(site, nb);
         t = '{default: 0};
         same = 1;
         for (int i = 0; i < 6; i++) begin
            nk[i] = kind_map[nb[i]];
            t[nk[i]]++;
            if (nk[i] != nk[0]) same = 0;
         end
         if (same) winner = nk[0];
         else begin
            winner = old_k;
            d = 0;
            acc = 0;
            for (int k = 1; k <= 3; k++) d += kind_weight(2'(k)) * t[k];
            if (d != 0) begin
               for (int k = 1; k <= 3; k++) begin
                  acc += kind_weight(2'(k)) * t[k];
                  if (acc * 65536 > longint'(w.compete_draw) * d) begin
                     winner = 2'(k);
                     break;
                  end
               end
            end
         end
         if (winner == hlc_pkg::KIND_INVADER && mut_thresh != 0 &&
             w.mutate_draw < mut_thresh)
            winner = hlc_pkg::KIND_MUTANT;
         res.new_kind = winner;
         if (winner != old_k) begin
            res.changed = 1;
            kind_map[site] = winner;
            entry_kind[pick] = winner;
            kind_tally[old_k]--;
            kind_tally[winner]++;
            // refresh the list for the neighbours and the cell itself
            for (int i = 0; i < 7; i++) begin
               x = (i < 6) ? nb[i] : site;
               if (on_list[x]) begin
                  if (all_alike(x)) list_drop(x);
               end else if (!all_alike(x)) list_push(x);
            end
         end
      end
      res.total = list_len[14:0];
      return res;
   endfunction

   // ---------------- bookkeeping ----------------
   event_word_type  pending_words[$];
   site_result_type expected_sites[$];
   int err_count = 0;
   int checked = 0;
   int start_words = 0, update_words = 0, empty_seen = 0, flips = 0, mutations = 0;
   int cycles = 0;

   task automatic report_mismatch(string field, int got, int want);
      $display("tb: %s mismatch on result %0d: got %0d, want %0d", field, checked, got, want);
      err_count++;
   endtask

   // ---------------- driver ----------------
   int burst_left = 4, gap_left = 0;
   always @(posedge clock) begin
      event_word_type w, acc_w;
      site_result_type p;
      if (reset) req_valid <= 0;
      else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            acc_w = '{req_func, req_rand_site, req_rand_compete, req_rand_mutate};
            p = lattice_event(acc_w);
            expected_sites = {expected_sites, p};
            if (acc_w.func == hlc_pkg::FUNC_START) start_words++;
            else update_words++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_func <= w.func;
            req_rand_site <= w.site_draw;
            req_rand_compete <= w.compete_draw;
            req_rand_mutate <= w.mutate_draw;
            req_valid <= 1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else req_valid <= 0;
      end
   end

   // ---------------- monitor ----------------
   int stall_left = 0, hold_left = 0;
   bit calm = 0, hold_done = 0;
   always @(posedge clock) begin
      site_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_sites.size() == 0) begin
            $display("tb: unexpected result word at row %0d col %0d",
                     rsp_site_row, rsp_site_col);
            err_count++;
         end else begin
            e = expected_sites.pop_front();
            if (rsp_site_row !== e.row)
               report_mismatch("site_row", int'(rsp_site_row), int'(e.row));
            if (rsp_site_col !== e.col)
               report_mismatch("site_col", int'(rsp_site_col), int'(e.col));
            if (rsp_old_type !== e.old_kind)
               report_mismatch("old_type", int'(rsp_old_type), int'(e.old_kind));
            if (rsp_new_type !== e.new_kind)
               report_mismatch("new_type", int'(rsp_new_type), int'(e.new_kind));
            if (rsp_changed !== e.changed)
               report_mismatch("changed", int'(rsp_changed), int'(e.changed));
            if (rsp_active_total !== e.total)
               report_mismatch("active_total", int'(rsp_active_total), int'(e.total));
            if (rsp_no_active !== e.empty)
               report_mismatch("no_active", int'(rsp_no_active), int'(e.empty));
            if (e.empty) empty_seen++;
            if (e.changed) flips++;
            if (e.changed && e.new_kind == hlc_pkg::KIND_MUTANT) mutations++;
         end
         checked++;
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && checked == 60) begin
         hold_done = 1;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_left = $urandom_range(20, 200);
            calm = ($urandom_range(0, 2) == 0);
         end
         stall_left--;
         rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // ---------------- timeout ----------------
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: done, errors");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         hlc_pkg::CSR_WEIGHT_RESIDENT:    wgt_resident = val;
         hlc_pkg::CSR_WEIGHT_MUTANT:      wgt_mutant = val;
         hlc_pkg::CSR_MUTATION_THRESHOLD: mut_thresh = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_sites.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic queue_word(logic f, logic [15:0] s, logic [15:0] c, logic [15:0] m);
      event_word_type w;
      w = '{f, s, c, m};
      pending_words = {pending_words, w};
   endtask

   // mostly uniform draws, some pinned to the ends
   function automatic logic [15:0] pick_draw();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic queue_random(int n);
      repeat (n) queue_word(hlc_pkg::FUNC_UPDATE, pick_draw(), pick_draw(), pick_draw());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;

      // empty list before any start, then a start and edge draws
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h0000, 16'h0000, 16'h0000);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_word(hlc_pkg::FUNC_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h0000, 16'h0000, 16'h0000);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h0000, 16'hFFFF, 16'h0000);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'hFFFF, 16'h0000, 16'hFFFF);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h8000, 16'h7FFF, 16'h5555);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h7FFF, 16'h8000, 16'hAAAA);
      wait_drained();

      // heavy residents, weightless mutants, mutation almost always
      write_reg(hlc_pkg::CSR_WEIGHT_RESIDENT, 16'hFFFF);
      write_reg(hlc_pkg::CSR_WEIGHT_MUTANT, 16'h0000);
      write_reg(hlc_pkg::CSR_MUTATION_THRESHOLD, 16'hFFFF);
      write_reg(CSR_UNUSED, 16'h1234);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h0000, 16'h0000, 16'h0000);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFE);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'h4000, 16'hC000, 16'hFFFF);
      queue_word(hlc_pkg::FUNC_UPDATE, 16'hC000, 16'h4000, 16'h0001);
      queue_random(70);
      wait_drained();

      // weightless residents, heavy mutants, even odds of mutation
      write_reg(hlc_pkg::CSR_WEIGHT_RESIDENT, 16'h0000);
      write_reg(hlc_pkg::CSR_WEIGHT_MUTANT, 16'hFFFF);
      write_reg(hlc_pkg::CSR_MUTATION_THRESHOLD, 16'h8000);
      queue_word(hlc_pkg::FUNC_START, 16'h0000, 16'h0000, 16'h0000);
      queue_random(70);
      wait_drained();

      write_reg(hlc_pkg::CSR_WEIGHT_RESIDENT, 16'h4000);
      write_reg(hlc_pkg::CSR_WEIGHT_MUTANT, 16'h6000);
      write_reg(hlc_pkg::CSR_MUTATION_THRESHOLD, 16'h0100);
      queue_random(70);
      wait_drained();

      // smallest nonzero settings on a fresh lattice
      write_reg(hlc_pkg::CSR_WEIGHT_RESIDENT, 16'h0001);
      write_reg(hlc_pkg::CSR_WEIGHT_MUTANT, 16'h0001);
      write_reg(hlc_pkg::CSR_MUTATION_THRESHOLD, 16'h0001);
      queue_word(hlc_pkg::FUNC_START, 16'h5A5A, 16'hA5A5, 16'h0000);
      queue_random(65);
      wait_drained();
      repeat (200) @(posedge clock);

      $display("tb: %0d start and %0d update words, %0d results checked", start_words,
               update_words, checked);
      $display("tb: %0d cells flipped, %0d to mutant, %0d empty-list events", flips,
               mutations, empty_seen);
      if (err_count == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/hlc_pkg.sv
rtl/core/hlc_serial_mul.sv
rtl/core/hex_lattice_competition_update.sv
rtl/core/hlc_checker.sv
tb/tb.sv
